### sv/tti_pkg.sv
// Shared types and constants for the thermistor table interpolator.
package tti_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);
  localparam int RES_W       = 24;
  localparam int TEMP_W      = 16;
  localparam int COUNT_W     = 10;
  localparam int ENTRY_W     = RES_W + TEMP_W;
  localparam int DIFF_W      = TEMP_W + 1;
  localparam int PROD_W      = RES_W + DIFF_W;
  localparam int STEP_W      = $clog2(DIFF_W + 1);

  localparam logic       FUNC_WRITE  = 1'b0;
  localparam logic       FUNC_LOOKUP = 1'b1;

  localparam logic [1:0] MATCH_EXACT       = 2'd0;
  localparam logic [1:0] MATCH_INTERP      = 2'd1;
  localparam logic [1:0] MATCH_CLAMP_FIRST = 2'd2;
  localparam logic [1:0] MATCH_CLAMP_LAST  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SEARCH,
    S_PROBE,
    S_LOWER,
    S_UPPER,
    S_MUL,
    S_DIVGO,
    S_DIV
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### sv/tti_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/tti_divider.sv
// Restoring serial divider: one quotient bit per cycle, quotient known to fit DIFF_W bits.
module tti_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tti_pkg::PROD_W-1:0] dividend,
  input  logic [tti_pkg::RES_W-1:0]  divisor,
  output logic [tti_pkg::DIFF_W-1:0] quotient,
  output tti_pkg::div_status_t       status
);

  logic [tti_pkg::RES_W-1:0]  rem;
  logic [tti_pkg::DIFF_W-1:0] low;
  logic [tti_pkg::STEP_W-1:0] steps;
  logic                       running;
  logic                       done;
  logic [tti_pkg::RES_W:0]    trial;
  logic                       fits;
  logic [tti_pkg::RES_W:0]    trial_sub;

  // The upper part of the dividend is already below the divisor, so only the
  // low DIFF_W bits need shifting in.
  always_comb begin
    trial     = {rem, low[tti_pkg::DIFF_W-1]};
    fits      = trial >= {1'b0, divisor};
    trial_sub = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= tti_pkg::STEP_W'(tti_pkg::DIFF_W);
        rem     <= dividend[tti_pkg::PROD_W-1 -: tti_pkg::RES_W];
        low     <= dividend[tti_pkg::DIFF_W-1:0];
      end else if (running) begin
        rem   <= fits ? trial_sub[tti_pkg::RES_W-1:0] : trial[tti_pkg::RES_W-1:0];
        low   <= {low[tti_pkg::DIFF_W-2:0], fits};
        steps <= steps - 1'b1;
        if (steps == tti_pkg::STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient    = low;
  assign status.busy = running;
  assign status.done = done;

endmodule

### sv/thermistor_table_interpolator_top.sv
// Thermistor table interpolator: table store, search sequencer and interpolation datapath.
//
// Input words are offered on start with func and the payload ports; a word is
// taken at a clock edge where start is high and busy is low. A write word
// (func 0) stores one table entry in that same cycle and leaves busy low, so
// writes can follow back to back. A lookup word (func 1) raises busy from the
// next cycle until its result word is on the outputs.
// The result word appears on temperature and match_kind for exactly one cycle
// with done high; the receiver cannot stall, so it must take it then. Busy is
// already low in that cycle, so the next word can be taken at the same edge.
// A lookup ends with a clamp at the first entry, a clamp at the last, an exact
// hit found by the binary search over the single table read port, or an
// interpolation between the two entries around the query, computed with a
// multiply and the serial divider when their resistances differ.
// One lookup is in flight. entry_count is written through config_we/config_data;
// the user must do so only while the block is idle, which the block itself does
// not enforce. Reset sets entry_count to 1 and the sequencer to idle; the table
// contents are not cleared and must be written before they are looked up.
module thermistor_table_interpolator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              func,
  input  logic [tti_pkg::ADDR_W-1:0]        entry_index,
  input  logic [tti_pkg::RES_W-1:0]         entry_resistance,
  input  logic signed [tti_pkg::TEMP_W-1:0] entry_temperature,
  input  logic [tti_pkg::RES_W-1:0]         query_resistance,
  input  logic                              config_we,
  input  logic [tti_pkg::COUNT_W-1:0]       config_data,
  output logic                              done,
  output logic signed [tti_pkg::TEMP_W-1:0] temperature,
  output logic [1:0]                        match_kind
);

  tti_pkg::state_t state, state_next;

  logic [tti_pkg::COUNT_W-1:0] entry_count;
  logic [tti_pkg::RES_W-1:0]   q, q_next;
  logic [tti_pkg::SIZE_W-1:0]  lo, lo_next;
  logic [tti_pkg::SIZE_W-1:0]  hp1, hp1_next;
  logic [tti_pkg::ADDR_W-1:0]  mid, mid_next;
  logic [tti_pkg::RES_W-1:0]   rl, rl_next;
  logic [tti_pkg::TEMP_W-1:0]  tl, tl_next;
  logic [tti_pkg::RES_W-1:0]   d, d_next;
  logic [tti_pkg::RES_W-1:0]   a, a_next;
  logic [tti_pkg::DIFF_W-1:0]  mag, mag_next;
  logic                        neg, neg_next;
  logic [tti_pkg::PROD_W-1:0]  prod;
  logic                        done_next;
  logic [tti_pkg::TEMP_W-1:0]  temp_next;
  logic [1:0]                  kind_next;

  logic [tti_pkg::SIZE_W-1:0]  n_act;
  logic [tti_pkg::ADDR_W-1:0]  last_idx;
  logic [tti_pkg::SIZE_W-1:0]  span;
  logic [tti_pkg::SIZE_W-1:0]  mid_calc;
  logic [tti_pkg::ADDR_W-1:0]  li;
  logic [tti_pkg::ADDR_W-1:0]  hiix;

  logic                        ram_we;
  logic [tti_pkg::ADDR_W-1:0]  raddr;
  logic [tti_pkg::ENTRY_W-1:0] rdata;
  logic [tti_pkg::RES_W-1:0]   r_rd;
  logic [tti_pkg::TEMP_W-1:0]  t_rd;

  logic signed [tti_pkg::DIFF_W-1:0] diff;
  logic [tti_pkg::RES_W-1:0]         span_r;
  logic [tti_pkg::RES_W-1:0]         offs;
  logic [tti_pkg::DIFF_W-1:0]        quotient;
  logic [tti_pkg::DIFF_W-1:0]        interp;
  logic                              div_start;
  tti_pkg::div_status_t              div_stat;

  assign ram_we = start && !busy && (func == tti_pkg::FUNC_WRITE);
  assign r_rd   = rdata[tti_pkg::ENTRY_W-1 -: tti_pkg::RES_W];
  assign t_rd   = rdata[tti_pkg::TEMP_W-1:0];

  tti_ram #(
    .WIDTH (tti_pkg::ENTRY_W),
    .DEPTH (tti_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_index),
    .wdata ({entry_resistance, entry_temperature}),
    .raddr (raddr),
    .rdata (rdata)
  );

  tti_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (d),
    .quotient (quotient),
    .status   (div_stat)
  );

  // Active table size: a count of zero acts as one, anything past the depth as the depth.
  always_comb begin
    if (entry_count == '0) begin
      n_act = tti_pkg::SIZE_W'(1);
    end else if (int'(entry_count) > tti_pkg::TABLE_DEPTH) begin
      n_act = tti_pkg::SIZE_W'(tti_pkg::TABLE_DEPTH);
    end else begin
      n_act = tti_pkg::SIZE_W'(entry_count);
    end
    last_idx = tti_pkg::ADDR_W'(n_act - 1'b1);
    span     = hp1 - 1'b1 - lo;
    mid_calc = lo + (span >> 1);
    li       = (lo >= n_act) ? last_idx : tti_pkg::ADDR_W'(lo);
    hiix     = (hp1 == '0) ? '0 : tti_pkg::ADDR_W'(hp1 - 1'b1);
    diff     = tti_pkg::DIFF_W'(signed'(t_rd)) - tti_pkg::DIFF_W'(signed'(tl));
    span_r   = r_rd - rl;
    if (q <= rl) begin
      offs = '0;
    end else if (q - rl > span_r) begin
      offs = span_r;
    end else begin
      offs = q - rl;
    end
    interp = neg ? tti_pkg::DIFF_W'(signed'(tl)) - quotient
                 : tti_pkg::DIFF_W'(signed'(tl)) + quotient;
  end

  always_comb begin
    state_next = state;
    q_next     = q;
    lo_next    = lo;
    hp1_next   = hp1;
    mid_next   = mid;
    rl_next    = rl;
    tl_next    = tl;
    d_next     = d;
    a_next     = a;
    mag_next   = mag;
    neg_next   = neg;
    done_next  = 1'b0;
    temp_next  = temperature;
    kind_next  = match_kind;
    raddr      = '0;
    div_start  = 1'b0;
    unique case (state)
      tti_pkg::S_IDLE: begin
        if (start && func == tti_pkg::FUNC_LOOKUP) begin
          q_next     = query_resistance;
          state_next = tti_pkg::S_FIRST;
        end
      end
      tti_pkg::S_FIRST: begin
        if (q > r_rd) begin
          temp_next  = t_rd;
          kind_next  = tti_pkg::MATCH_CLAMP_FIRST;
          done_next  = 1'b1;
          state_next = tti_pkg::S_IDLE;
        end else begin
          raddr      = last_idx;
          state_next = tti_pkg::S_LAST;
        end
      end
      tti_pkg::S_LAST: begin
        if (q < r_rd) begin
          temp_next  = t_rd;
          kind_next  = tti_pkg::MATCH_CLAMP_LAST;
          done_next  = 1'b1;
          state_next = tti_pkg::S_IDLE;
        end else begin
          lo_next    = '0;
          hp1_next   = n_act;
          state_next = tti_pkg::S_SEARCH;
        end
      end
      tti_pkg::S_SEARCH: begin
        // hp1 holds the upper search bound plus one, so an empty range is lo >= hp1.
        if (lo < hp1) begin
          raddr      = tti_pkg::ADDR_W'(mid_calc);
          mid_next   = tti_pkg::ADDR_W'(mid_calc);
          state_next = tti_pkg::S_PROBE;
        end else begin
          raddr      = li;
          state_next = tti_pkg::S_LOWER;
        end
      end
      tti_pkg::S_PROBE: begin
        if (r_rd == q) begin
          temp_next  = t_rd;
          kind_next  = tti_pkg::MATCH_EXACT;
          done_next  = 1'b1;
          state_next = tti_pkg::S_IDLE;
        end else begin
          if (r_rd > q) begin
            lo_next = tti_pkg::SIZE_W'(mid) + 1'b1;
          end else begin
            hp1_next = tti_pkg::SIZE_W'(mid);
          end
          state_next = tti_pkg::S_SEARCH;
        end
      end
      tti_pkg::S_LOWER: begin
        rl_next    = r_rd;
        tl_next    = t_rd;
        raddr      = hiix;
        state_next = tti_pkg::S_UPPER;
      end
      tti_pkg::S_UPPER: begin
        if (r_rd <= rl) begin
          temp_next  = tl;
          kind_next  = tti_pkg::MATCH_INTERP;
          done_next  = 1'b1;
          state_next = tti_pkg::S_IDLE;
        end else begin
          d_next     = span_r;
          a_next     = offs;
          neg_next   = diff[tti_pkg::DIFF_W-1];
          mag_next   = diff[tti_pkg::DIFF_W-1] ? tti_pkg::DIFF_W'(-diff)
                                               : tti_pkg::DIFF_W'(diff);
          state_next = tti_pkg::S_MUL;
        end
      end
      tti_pkg::S_MUL: begin
        state_next = tti_pkg::S_DIVGO;
      end
      tti_pkg::S_DIVGO: begin
        div_start  = 1'b1;
        state_next = tti_pkg::S_DIV;
      end
      tti_pkg::S_DIV: begin
        if (div_stat.done) begin
          temp_next  = interp[tti_pkg::TEMP_W-1:0];
          kind_next  = tti_pkg::MATCH_INTERP;
          done_next  = 1'b1;
          state_next = tti_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tti_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tti_pkg::S_IDLE;
      done        <= 1'b0;
      entry_count <= tti_pkg::COUNT_W'(1);
    end else begin
      state <= state_next;
      done  <= done_next;
      if (config_we) begin
        entry_count <= config_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    q           <= q_next;
    lo          <= lo_next;
    hp1         <= hp1_next;
    mid         <= mid_next;
    rl          <= rl_next;
    tl          <= tl_next;
    d           <= d_next;
    a           <= a_next;
    mag         <= mag_next;
    neg         <= neg_next;
    temperature <= temp_next;
    match_kind  <= kind_next;
    if (state == tti_pkg::S_MUL) begin
      prod <= tti_pkg::PROD_W'(a) * tti_pkg::PROD_W'(mag);
    end
  end

  assign busy = (state != tti_pkg::S_IDLE);

endmodule

### sv/tti_checker.sv
// Port-level checks for the thermistor table interpolator, bound to the top level.
module tti_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic func,
  input logic done
);

  // A result word only ever ends a lookup.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a lookup in progress");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result word repeated");

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == tti_pkg::FUNC_LOOKUP) |=> busy)
    else $error("lookup word taken but block not busy");

  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == tti_pkg::FUNC_WRITE) |=> (!busy && !done))
    else $error("write word caused activity");

  a_end_with_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("lookup finished without a result word");

endmodule

bind thermistor_table_interpolator_top tti_checker u_tti_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .func  (func),
  .done  (done)
);
